// ===== hdl/dap_pkg.sv =====
// Package: payload structs and constants for the digitizer aggregate parser.
package dap_pkg;

    localparam logic [3:0] BOARD_TAG = 4'hA;

    localparam logic [1:0] KIND_EVENT  = 2'd0;
    localparam logic [1:0] KIND_SINGLE = 2'd1;
    localparam logic [1:0] KIND_DUAL   = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    localparam logic [15:0] ADDR_BASE = 16'h8000;

    typedef struct packed {
        logic [31:0] word;
        logic        last_word;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] address;
        logic [46:0] timestamp;
        logic [15:0] energy;
        logic [14:0] short_charge;
        logic        overrange;
        logic [3:0]  flags;
        logic [9:0]  fine_time;
        logic [31:0] trigger_counts;
        logic [13:0] sample_a;
        logic [13:0] sample_b;
        logic [3:0]  probe_bits;
    } out_beat_t;

endpackage

// ===== hdl/digitizer_aggregate_parser.sv =====
// Top level: streaming decoder for PSD channel-aggregate readout buffers.
// Throughput: one word per cycle while the output is not stalled, except the second
// channel header word, which holds the input stalled while the restoring divider runs.
// A result sits in the output register the cycle after its word, or after the divide.
// Reset: asynchronous, active low; parser awaits a board header, output empty.
// Stall is also raised while the output register is full and stalled.
module digitizer_aggregate_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  dap_pkg::in_beat_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output dap_pkg::out_beat_t  out_data
);

    typedef enum logic [3:0] {
        PH_BOARD_HDR, PH_BOARD_ID, PH_BOARD_CNT, PH_BOARD_TIME,
        PH_CH_HDR0, PH_CH_HDR1, PH_DIV, PH_EV_TIME, PH_EV_SAMPLES,
        PH_EV_EXTRAS, PH_EV_CHARGE, PH_SKIP
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [4:0]  board_id_reg, board_id_next;
    logic [7:0]  mask_reg, mask_next;
    logic [2:0]  pair_reg, pair_next;
    logic [21:0] events_reg, events_next;
    logic [17:0] nsw_reg, nsw_next;
    logic [17:0] scount_reg, scount_next;
    logic [5:0]  fmt_reg, fmt_next;
    logic [15:0] addr_reg, addr_next;
    logic [46:0] time_reg, time_next;
    logic [45:0] extras_reg, extras_next;
    logic [27:0] owed_reg, owed_next;
    // divider: remainder, quotient, divisor, step count, last flag of held word
    logic [18:0] rem_reg, rem_next;
    logic [21:0] quo_reg, quo_next;
    logic [18:0] size_reg, size_next;
    logic [4:0]  step_reg, step_next;
    logic        dlast_reg, dlast_next;
    logic        ovalid_reg, ovalid_next;
    dap_pkg::out_beat_t obeat_reg, obeat_next;

    logic        accept, oready;
    logic [31:0] w;
    logic        lst;

    assign oready    = !ovalid_reg || !out_stall;
    assign in_stall  = !oready || (phase_reg == PH_DIV);
    assign accept    = in_valid && !in_stall;
    assign out_valid = ovalid_reg;
    assign out_data  = obeat_reg;
    assign w   = in_data.word;
    assign lst = in_data.last_word;

    // find next set pair at or above start
    function automatic logic [3:0] seek(input logic [7:0] m, input logic [3:0] start);
        logic [3:0] r;
        r = 4'd8;
        for (int p = 7; p >= 0; p--)
            if (m[p] && 4'(p) >= start)
                r = 4'(p);
        return r;
    endfunction

    always_comb
    begin
        logic        err;
        logic [3:0]  sk;
        logic [27:0] owed_dec;
        logic [19:0] trial;
        logic [21:0] ev;
        logic [2:0]  xf;
        logic        emit;
        phase_next  = phase_reg;
        board_id_next = board_id_reg;
        mask_next   = mask_reg;
        pair_next   = pair_reg;
        events_next = events_reg;
        nsw_next    = nsw_reg;
        scount_next = scount_reg;
        fmt_next    = fmt_reg;
        addr_next   = addr_reg;
        time_next   = time_reg;
        extras_next = extras_reg;
        owed_next   = owed_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        size_next   = size_reg;
        step_next   = step_reg;
        dlast_next  = dlast_reg;
        ovalid_next = ovalid_reg && out_stall;
        obeat_next  = obeat_reg;
        err  = 1'b0;
        emit = 1'b0;
        sk   = 4'd0;
        trial = 20'd0;
        ev   = 22'd0;
        xf   = fmt_reg[5:3];
        owed_dec = (owed_reg != 28'd0) ? owed_reg - 28'd1 : owed_reg;

        if (phase_reg == PH_DIV)
        begin
            // one restoring divide step per cycle over the 22-bit word count
            trial = {rem_reg, quo_reg[21]} - {1'b0, size_reg};
            if (!trial[19])
            begin
                rem_next = trial[18:0];
                quo_next = {quo_reg[20:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[17:0], quo_reg[21]};
                quo_next = {quo_reg[20:0], 1'b0};
            end
            step_next = step_reg + 5'd1;
            if (step_reg == 5'd21)
            begin
                // quotient of count/size; (count-2)/size equals it when rem==2
                ev = quo_next;
                if (!(rem_next == 19'd2 || (size_reg == 19'd2 && rem_next == 19'd0)))
                    err = 1'b1;
                else
                begin
                    if (size_reg == 19'd2 && rem_next == 19'd0 && ev != 22'd0)
                        ev = ev - 22'd1;
                    events_next = ev;
                    if (ev == 22'd0)
                    begin
                        sk = seek(mask_reg, {1'b0, pair_reg} + 4'd1);
                        if (sk[3]) phase_next = PH_BOARD_HDR;
                        else
                        begin
                            phase_next = PH_CH_HDR0;
                            pair_next  = sk[2:0];
                        end
                    end
                    else
                        phase_next = PH_EV_TIME;
                end
                if (!err && dlast_reg && (phase_next != PH_BOARD_HDR || owed_reg != 28'd0))
                    err = 1'b1;
                if (err)
                begin
                    emit = 1'b1;
                    obeat_next = '0;
                    obeat_next.kind = dap_pkg::KIND_ERROR;
                    phase_next = dlast_reg ? PH_BOARD_HDR : PH_SKIP;
                end
                if (dlast_reg)
                begin
                    owed_next = 28'd0;
                    if (!err) phase_next = PH_BOARD_HDR;
                end
            end
        end
        else if (accept)
        begin
            if (phase_reg == PH_SKIP)
            begin
                if (lst)
                begin
                    phase_next = PH_BOARD_HDR;
                    owed_next  = 28'd0;
                end
            end
            else
            begin
                owed_next = owed_dec;
                unique case (phase_reg)
                    PH_BOARD_HDR:
                    begin
                        if (w[31:28] != dap_pkg::BOARD_TAG) err = 1'b1;
                        else
                        begin
                            if (w[27:0] != 28'd0 && (w[27:0] - 28'd1) > owed_dec)
                                owed_next = w[27:0] - 28'd1;
                            phase_next = PH_BOARD_ID;
                        end
                    end
                    PH_BOARD_ID:
                    begin
                        board_id_next = w[31:27];
                        mask_next     = w[7:0];
                        phase_next    = PH_BOARD_CNT;
                    end
                    PH_BOARD_CNT: phase_next = PH_BOARD_TIME;
                    PH_BOARD_TIME:
                    begin
                        sk = seek(mask_reg, 4'd0);
                        if (sk[3]) phase_next = PH_BOARD_HDR;
                        else
                        begin
                            phase_next = PH_CH_HDR0;
                            pair_next  = sk[2:0];
                        end
                    end
                    PH_CH_HDR0:
                    begin
                        if (!w[31]) err = 1'b1;
                        else
                        begin
                            events_next = w[21:0];
                            phase_next  = PH_CH_HDR1;
                        end
                    end
                    PH_CH_HDR1:
                    begin
                        if (w[30:29] != 2'b11) err = 1'b1;
                        else
                        begin
                            fmt_next  = {w[26:24], w[27], w[28], w[31]};
                            nsw_next  = {w[15:0], 2'b00};
                            size_next = {1'b0, w[15:0], 2'b00} + 19'd2 + 19'(w[28]);
                            rem_next  = 19'd0;
                            quo_next  = events_reg;
                            step_next = 5'd0;
                            dlast_next = lst;
                            phase_next = PH_DIV;
                        end
                    end
                    PH_EV_TIME:
                    begin
                        addr_next = dap_pkg::ADDR_BASE + {3'd0, board_id_reg, 8'd0}
                                  + {12'd0, pair_reg, 1'b0} + {15'd0, w[31]};
                        time_next   = {16'd0, w[30:0]};
                        extras_next = '0;
                        scount_next = '0;
                        if (fmt_reg[2] && nsw_reg != 18'd0) phase_next = PH_EV_SAMPLES;
                        else phase_next = fmt_reg[1] ? PH_EV_EXTRAS : PH_EV_CHARGE;
                    end
                    PH_EV_SAMPLES:
                    begin
                        emit = 1'b1;
                        obeat_next = '0;
                        obeat_next.kind = fmt_reg[0] ? dap_pkg::KIND_DUAL
                                                     : dap_pkg::KIND_SINGLE;
                        obeat_next.address    = addr_reg;
                        obeat_next.timestamp  = time_reg;
                        obeat_next.sample_a   = w[13:0];
                        obeat_next.sample_b   = w[29:16];
                        obeat_next.probe_bits = {w[31], w[30], w[15], w[14]};
                        scount_next = scount_reg + 18'd1;
                        if (scount_next >= nsw_reg)
                            phase_next = fmt_reg[1] ? PH_EV_EXTRAS : PH_EV_CHARGE;
                    end
                    PH_EV_EXTRAS:
                    begin
                        if (xf == 3'd0 || xf == 3'd1 || xf == 3'd2)
                            time_next = time_reg | {w[31:16], 31'd0};
                        if (xf == 3'd1 || xf == 3'd2)
                            extras_next[3:0] = extras_reg[3:0] | w[15:12];
                        if (xf == 3'd2)
                            extras_next[13:4] = extras_reg[13:4] | w[9:0];
                        if (xf == 3'd4)
                            extras_next[45:14] = extras_reg[45:14] | w;
                        phase_next = PH_EV_CHARGE;
                    end
                    PH_EV_CHARGE:
                    begin
                        emit = 1'b1;
                        obeat_next = '0;
                        obeat_next.kind      = dap_pkg::KIND_EVENT;
                        obeat_next.address   = addr_reg;
                        obeat_next.timestamp = time_reg;
                        obeat_next.energy    = w[31:16];
                        obeat_next.short_charge = w[14:0];
                        obeat_next.overrange = w[15];
                        obeat_next.flags     = extras_reg[3:0];
                        obeat_next.fine_time = extras_reg[13:4];
                        obeat_next.trigger_counts = extras_reg[45:14];
                        ev = (events_reg != 22'd0) ? events_reg - 22'd1 : events_reg;
                        events_next = ev;
                        if (ev != 22'd0) phase_next = PH_EV_TIME;
                        else
                        begin
                            sk = seek(mask_reg, {1'b0, pair_reg} + 4'd1);
                            if (sk[3]) phase_next = PH_BOARD_HDR;
                            else
                            begin
                                phase_next = PH_CH_HDR0;
                                pair_next  = sk[2:0];
                            end
                        end
                    end
                    default: err = 1'b1;
                endcase

                // the channel header check resolves later in the divider
                if (phase_next != PH_DIV)
                begin
                    if (!err && lst && (phase_next != PH_BOARD_HDR || owed_next != 28'd0))
                        err = 1'b1;
                    if (err)
                    begin
                        emit = 1'b1;
                        obeat_next = '0;
                        obeat_next.kind = dap_pkg::KIND_ERROR;
                        phase_next = lst ? PH_BOARD_HDR : PH_SKIP;
                    end
                    if (lst)
                    begin
                        owed_next = 28'd0;
                        if (!err) phase_next = PH_BOARD_HDR;
                    end
                end
            end
        end
        if (emit) ovalid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_BOARD_HDR;
            board_id_reg <= '0;
            mask_reg     <= '0;
            pair_reg     <= '0;
            events_reg   <= '0;
            nsw_reg      <= '0;
            scount_reg   <= '0;
            fmt_reg      <= '0;
            addr_reg     <= '0;
            time_reg     <= '0;
            extras_reg   <= '0;
            owed_reg     <= '0;
            step_reg     <= '0;
            dlast_reg    <= 1'b0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            board_id_reg <= board_id_next;
            mask_reg     <= mask_next;
            pair_reg     <= pair_next;
            events_reg   <= events_next;
            nsw_reg      <= nsw_next;
            scount_reg   <= scount_next;
            fmt_reg      <= fmt_next;
            addr_reg     <= addr_next;
            time_reg     <= time_next;
            extras_reg   <= extras_next;
            owed_reg     <= owed_next;
            step_reg     <= step_next;
            dlast_reg    <= dlast_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        size_reg  <= size_next;
        obeat_reg <= obeat_next;
    end

endmodule
